@@ rtl/piddq_pkg.sv @@
// Package: shared types and constants for the process id deque.
`default_nettype none

package piddq_pkg;

    localparam int DATA_W       = 16;
    localparam int MODE_W       = 3;
    localparam int STATUS_W     = 2;
    localparam int COUNT_W      = 6;
    localparam int CAPACITY_DEF = 32;

    typedef enum logic [MODE_W-1:0] {
        MODE_PUSH_FRONT = 3'd0,
        MODE_PUSH_BACK  = 3'd1,
        MODE_POP_FRONT  = 3'd2,
        MODE_POP_BACK   = 3'd3,
        MODE_REMOVE     = 3'd4
    } mode_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_SHIFT_RIGHT,
        CELL_SHIFT_LEFT,
        CELL_WRITE_AT,
        CELL_ROTATE
    } cell_op_t;

    typedef struct packed {
        cell_op_t            op;
        logic [DATA_W-1:0]   value;
    } cell_ctrl_t;

    typedef enum logic {
        FSM_IDLE,
        FSM_SCAN
    } fsm_t;

endpackage

`default_nettype wire

@@ rtl/piddq_if.sv @@
// Interfaces: request and response channels of the process id deque.
`default_nettype none

interface piddq_req_if;
    logic                           valid;
    logic                           ready;
    logic [piddq_pkg::MODE_W-1:0]   mode;
    logic [piddq_pkg::DATA_W-1:0]   value;

    modport source (output valid, output mode, output value, input ready);
    modport sink   (input valid, input mode, input value, output ready);
endinterface

interface piddq_rsp_if;
    logic                           valid;
    logic                           ready;
    logic [piddq_pkg::DATA_W-1:0]   popped;
    logic [piddq_pkg::STATUS_W-1:0] status;
    logic [piddq_pkg::COUNT_W-1:0]  count;

    modport source (output valid, output popped, output status, output count, input ready);
    modport sink   (input valid, input popped, input status, input count, output ready);
endinterface

`default_nettype wire

@@ rtl/piddq_cell.sv @@
// Storage cell: one deque position, loads from a neighbor, the head or the request.
`default_nettype none

module piddq_cell #(
    parameter int IDX_W = 6,
    parameter int INDEX = 0
) (
    input  wire                                clk,
    input  wire piddq_pkg::cell_ctrl_t         ctrl,
    input  wire logic [IDX_W-1:0]              tail,
    input  wire logic [piddq_pkg::DATA_W-1:0]  left_data,
    input  wire logic [piddq_pkg::DATA_W-1:0]  right_data,
    input  wire logic [piddq_pkg::DATA_W-1:0]  head_data,
    output logic      [piddq_pkg::DATA_W-1:0]  data
);
    import piddq_pkg::*;

    logic [DATA_W-1:0] data_reg;
    logic [DATA_W-1:0] data_next;
    logic              hit;

    assign hit  = (tail == IDX_W'(INDEX));
    assign data = data_reg;

    always_comb
    begin
        data_next = data_reg;
        case (ctrl.op)
            CELL_SHIFT_RIGHT: data_next = left_data;
            CELL_SHIFT_LEFT:  data_next = right_data;
            CELL_WRITE_AT:    data_next = hit ? ctrl.value : data_reg;
            CELL_ROTATE:      data_next = hit ? head_data : right_data;
            default:          data_next = data_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

endmodule

`default_nettype wire

@@ rtl/process_id_deque_with_remove_core.sv @@
// Top level: bounded deque of process ids with remove-by-value, built as a row of cells.
//
// Requests arrive on req (mode, value), one response per request leaves on rsp
// (popped, status, count). Both channels transfer on valid && ready.
// Cell 0 always holds the front entry; entries close up toward cell 0.
// Push front, push back, pop front and unused modes answer directly: the
// response is registered at the accept edge and shows on the next cycle.
// Pop back and remove walk the stored entries through the row: each cycle the
// front entry is either dropped or rotated to the tail, once for each held
// entry, before the response is loaded; on an empty store they answer like
// the modes above, without a walk.
// One request is worked at a time; req.ready is low during a walk.
// The response register holds its transaction while rsp.ready is low; a new
// request is accepted in the cycle the pending response is taken.
// Reset clears the entry count, the control state and the response valid;
// cell contents are not reset and are only read once written.
`default_nettype none

module process_id_deque_with_remove_core #(
    parameter int CAPACITY = piddq_pkg::CAPACITY_DEF
) (
    input  wire         clk,
    input  wire         rst_n,
    piddq_req_if.sink   req,
    piddq_rsp_if.source rsp
);
    import piddq_pkg::*;

    localparam int IDX_W = $clog2(CAPACITY + 1);

    logic [DATA_W-1:0]   data [CAPACITY];
    cell_ctrl_t          ctrl;
    logic [IDX_W-1:0]    tail;

    fsm_t                state_reg,  state_next;
    logic [IDX_W-1:0]    occ_reg,    occ_next;
    logic [IDX_W-1:0]    steps_reg,  steps_next;
    logic                found_reg,  found_next;
    logic                back_reg,   back_next;
    logic [DATA_W-1:0]   val_reg,    val_next;
    logic [DATA_W-1:0]   hold_reg,   hold_next;

    logic                out_valid_reg, out_valid_next;
    logic [DATA_W-1:0]   out_popped_reg, out_popped_next;
    logic [STATUS_W-1:0] out_status_reg, out_status_next;
    logic [COUNT_W-1:0]  out_count_reg,  out_count_next;

    logic                load_out;
    logic [DATA_W-1:0]   res_popped;
    status_t             res_status;
    logic                req_ready;
    logic                full;
    logic                empty;
    logic                drop;

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++)
        begin : g_cell
            logic [DATA_W-1:0] left_d;
            logic [DATA_W-1:0] right_d;
            if (g == 0)
            begin : g_first
                assign left_d = ctrl.value;
            end
            else
            begin : g_mid_l
                assign left_d = data[g-1];
            end
            if (g == CAPACITY - 1)
            begin : g_last
                assign right_d = data[g];
            end
            else
            begin : g_mid_r
                assign right_d = data[g+1];
            end
            piddq_cell #(
                .IDX_W (IDX_W),
                .INDEX (g)
            ) u_cell (
                .clk        (clk),
                .ctrl       (ctrl),
                .tail       (tail),
                .left_data  (left_d),
                .right_data (right_d),
                .head_data  (data[0]),
                .data       (data[g])
            );
        end
    endgenerate

    assign full      = (occ_reg == IDX_W'(CAPACITY));
    assign empty     = (occ_reg == '0);
    assign req_ready = (state_reg == FSM_IDLE) && (!out_valid_reg || rsp.ready);
    assign drop      = !found_reg && (back_reg ? (steps_reg == IDX_W'(1))
                                               : (data[0] == val_reg));

    always_comb
    begin
        state_next = state_reg;
        occ_next   = occ_reg;
        steps_next = steps_reg;
        found_next = found_reg;
        back_next  = back_reg;
        val_next   = val_reg;
        hold_next  = hold_reg;
        ctrl.op    = CELL_HOLD;
        ctrl.value = req.value;
        tail       = occ_reg;
        load_out   = 1'b0;
        res_popped = '0;
        res_status = ST_OK;

        unique case (state_reg)
            FSM_IDLE:
            begin
                if (req.valid && req_ready)
                begin
                    load_out = 1'b1;
                    case (mode_t'(req.mode))
                        MODE_PUSH_FRONT:
                        begin
                            if (full)
                            begin
                                res_status = ST_FULL;
                            end
                            else
                            begin
                                ctrl.op  = CELL_SHIFT_RIGHT;
                                occ_next = occ_reg + IDX_W'(1);
                            end
                        end
                        MODE_PUSH_BACK:
                        begin
                            if (full)
                            begin
                                res_status = ST_FULL;
                            end
                            else
                            begin
                                ctrl.op  = CELL_WRITE_AT;
                                occ_next = occ_reg + IDX_W'(1);
                            end
                        end
                        MODE_POP_FRONT:
                        begin
                            if (empty)
                            begin
                                res_status = ST_EMPTY;
                            end
                            else
                            begin
                                ctrl.op    = CELL_SHIFT_LEFT;
                                res_popped = data[0];
                                occ_next   = occ_reg - IDX_W'(1);
                            end
                        end
                        MODE_POP_BACK, MODE_REMOVE:
                        begin
                            if (empty)
                            begin
                                res_status = ST_EMPTY;
                            end
                            else
                            begin
                                load_out   = 1'b0;
                                state_next = FSM_SCAN;
                                steps_next = occ_reg;
                                found_next = 1'b0;
                                back_next  = (mode_t'(req.mode) == MODE_POP_BACK);
                                val_next   = req.value;
                                hold_next  = '0;
                            end
                        end
                        default:
                        begin
                            res_status = ST_OK;
                        end
                    endcase
                end
            end
            FSM_SCAN:
            begin
                tail       = occ_reg - IDX_W'(1);
                steps_next = steps_reg - IDX_W'(1);
                if (drop)
                begin
                    ctrl.op    = CELL_SHIFT_LEFT;
                    occ_next   = occ_reg - IDX_W'(1);
                    found_next = 1'b1;
                    hold_next  = data[0];
                end
                else
                begin
                    ctrl.op = CELL_ROTATE;
                end
                if (steps_reg == IDX_W'(1))
                begin
                    load_out   = 1'b1;
                    state_next = FSM_IDLE;
                    res_popped = hold_next;
                    res_status = (found_reg || drop) ? ST_OK : ST_EMPTY;
                end
            end
            default:
            begin
                state_next = FSM_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_popped_next = out_popped_reg;
        out_status_next = out_status_reg;
        out_count_next  = out_count_reg;
        if (load_out)
        begin
            out_valid_next  = 1'b1;
            out_popped_next = res_popped;
            out_status_next = res_status;
            out_count_next  = COUNT_W'(occ_next);
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= FSM_IDLE;
            occ_reg       <= '0;
            steps_reg     <= '0;
            found_reg     <= 1'b0;
            back_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            occ_reg       <= occ_next;
            steps_reg     <= steps_next;
            found_reg     <= found_next;
            back_reg      <= back_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg        <= val_next;
        hold_reg       <= hold_next;
        out_popped_reg <= out_popped_next;
        out_status_reg <= out_status_next;
        out_count_reg  <= out_count_next;
    end

    assign req.ready  = req_ready;
    assign rsp.valid  = out_valid_reg;
    assign rsp.popped = out_popped_reg;
    assign rsp.status = out_status_reg;
    assign rsp.count  = out_count_reg;

endmodule

`default_nettype wire

@@ rtl/piddq_checker.sv @@
// Checker: port-level assertions for the process id deque, bound to the top level.
`default_nettype none

module piddq_checker (
    input wire                                 clk,
    input wire                                 rst_n,
    input wire                                 rsp_valid,
    input wire                                 rsp_ready,
    input wire logic [piddq_pkg::DATA_W-1:0]   rsp_popped,
    input wire logic [piddq_pkg::STATUS_W-1:0] rsp_status,
    input wire logic [piddq_pkg::COUNT_W-1:0]  rsp_count
);
    import piddq_pkg::*;

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_popped)
            && $stable(rsp_status) && $stable(rsp_count))
        else $error("response changed while stalled");

    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp_status == ST_EMPTY) |-> (rsp_popped == '0))
        else $error("empty or not-found response carries a value");

    a_full_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp_status == ST_FULL) |-> (rsp_popped == '0))
        else $error("refused push carries a value");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp_status == ST_OK) || (rsp_status == ST_EMPTY)
            || (rsp_status == ST_FULL))
        else $error("undefined status code");

endmodule

bind process_id_deque_with_remove_core piddq_checker u_piddq_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .rsp_valid  (rsp.valid),
    .rsp_ready  (rsp.ready),
    .rsp_popped (rsp.popped),
    .rsp_status (rsp.status),
    .rsp_count  (rsp.count)
);

`default_nettype wire
